[hdl/stack_machine_execute_top_assert.svh]
// Assertion macros used by the checker file of the stack machine block.
// Both macros sample on the rising edge of clock and are disabled during reset.
`ifndef STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH

// A property that must hold in the same cycle as its antecedent.
`define SME_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A property whose consequent must hold in the cycle after its antecedent.
`define SME_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/sme_pkg.sv]
package sme_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 256;
   localparam int WORD_WIDTH  = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // Widths of the interface fields.
   localparam int KIND_W  = 4;
   localparam int PUSH_W  = 32;
   localparam int OUT_W   = 32;
   localparam int DEPTH_W = 9;
   localparam int ERR_W   = 3;

   // Result beat layout on rsp_tdata, lowest field first.
   localparam int OUT_VALUE_LSB = 0;
   localparam int OUT_VALID_BIT = OUT_VALUE_LSB + OUT_W;
   localparam int STORED_LSB    = OUT_VALID_BIT + 1;
   localparam int DEPTH_LSB     = STORED_LSB + OUT_W;
   localparam int ERR_LSB       = DEPTH_LSB + DEPTH_W;
   localparam int RSP_FIELDS_W  = ERR_LSB + ERR_W;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_FIELDS_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH     = 4'd0,
      KIND_POP      = 4'd1,
      KIND_STORE    = 4'd2,
      KIND_REVERSE  = 4'd3,
      KIND_PUT_NUM  = 4'd4,
      KIND_PUT_CHAR = 4'd5,
      KIND_DUP      = 4'd6,
      KIND_SWAP     = 4'd7,
      KIND_SUB      = 4'd8,
      KIND_ADD      = 4'd9
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK     = 3'd0,
      ERR_EMPTY  = 3'd1,
      ERR_ONE    = 3'd2,
      ERR_FULL   = 3'd3,
      ERR_HALTED = 3'd4
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OPA,
      ST_OPB,
      ST_SWAP2,
      ST_REV_A,
      ST_REV_B,
      ST_REV_C,
      ST_REV_D,
      ST_RESULT
   } state_type;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // Sign-extend or wrap a pushed word to the stack word width.
   function automatic word_type to_word(input logic signed [PUSH_W-1:0] v);
      return WORD_WIDTH'(v);
   endfunction

   // Sign-extend or wrap a stack word to the output field width.
   function automatic logic [OUT_W-1:0] to_out(input logic signed [WORD_WIDTH-1:0] w);
      return OUT_W'(w);
   endfunction

endpackage

[hdl/stack_machine_execute_top.sv]
// Stack machine execute block. Each request beat carries one instruction (kind on
// req_tuser, push value on req_tdata) and produces exactly one response beat that
// reports any emitted value, the store register, the stack depth after the
// instruction and an error code. The stack lives in a 256 x 32 synchronous RAM with
// one write port and one registered read port; the top-of-stack address is read
// every idle cycle so that its data is ready the cycle after a beat is taken. One
// instruction is in flight at a time, and its steps are set by the RAM port:
// push, errors and ignored kinds go straight to the result, pop, store-pop, put
// and dup first read the top, sub and add also read the item below it and write
// the sum or difference, swap then writes both items, and reverse of at least two
// items needs two reads and two writes per pair, with nothing to do for fewer.
// A finished result sits in an output register, so the block accepts the
// next beat while a response is still stalled downstream. A fault (empty stack, a
// single item for a two-operand op, or a full stack) leaves the stack untouched,
// sets a sticky halt flag, and every later instruction answers with the halted code
// until reset. The stack RAM needs no clearing after reset: only entries below the
// current depth are ever used.
module stack_machine_execute_top
   import sme_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PUSH_W-1:0]      req_tdata,   // [31:0] push_value
   input  logic [KIND_W-1:0]      req_tuser,   // [3:0] kind

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] out_value, [32] out_valid,
                                               // [64:33] stored_value,
                                               // [73:65] stack_depth,
                                               // [76:74] error_code, [79:77] zero
   output logic                   rsp_tuser    // [0] out_is_char
);

   // Control state.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 halted_ff, halted_in;
   kind_type             kind_ff, kind_in;
   err_type              err_ff, err_in;
   word_type             store_ff, store_in;

   // Working registers: first operand (or the low word during reverse) and the
   // two walking pointers of the reverse sweep.
   word_type             opa_ff, opa_in;
   logic [ADDR_W-1:0]    lo_ff, lo_in;
   logic [ADDR_W-1:0]    hi_ff, hi_in;

   // Emitted value of the instruction in flight.
   logic [OUT_W-1:0]     emit_ff, emit_in;
   logic                 emit_valid_ff, emit_valid_in;
   logic                 emit_char_ff, emit_char_in;

   // Output register.
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tuser_ff, rsp_tuser_in;

   // Stack RAM port.
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   word_type             mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;
   word_type             mem_rdata;

   kind_type             req_kind;
   err_type              req_err;
   logic [ADDR_W-1:0]    top_addr;
   logic [ADDR_W-1:0]    next_addr;
   logic [ADDR_W-1:0]    second_addr;
   logic [ADDR_W:0]      lo_plus2;
   logic                 rev_more;
   logic                 out_free;
   logic                 take;

   sme_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_kind    = kind_type'(req_tuser);
   assign req_tready  = (state_ff == ST_IDLE);
   assign take        = req_tvalid && req_tready;

   // Addresses relative to the current depth. When the stack is too shallow these
   // wrap, but such addresses are only used by instructions that were checked.
   assign top_addr    = ADDR_W'(count_ff - CNT_W'(1));
   assign second_addr = ADDR_W'(count_ff - CNT_W'(2));
   assign next_addr   = ADDR_W'(count_ff);

   // The reverse sweep continues while the pointers, after stepping, still cross.
   assign lo_plus2 = {1'b0, lo_ff} + (ADDR_W + 1)'(2);
   assign rev_more = lo_plus2 < {1'b0, hi_ff};

   // The output register can take a new result when it is empty or being drained.
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Fault check of an incoming instruction against the current depth.
   always_comb begin
      req_err = ERR_OK;
      if (halted_ff) begin
         req_err = ERR_HALTED;
      end else begin
         case (req_kind)
            KIND_PUSH: begin
               if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                  req_err = ERR_FULL;
               end
            end
            KIND_POP, KIND_STORE, KIND_PUT_NUM, KIND_PUT_CHAR: begin
               if (count_ff == '0) begin
                  req_err = ERR_EMPTY;
               end
            end
            KIND_DUP: begin
               if (count_ff == '0) begin
                  req_err = ERR_EMPTY;
               end else if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                  req_err = ERR_FULL;
               end
            end
            KIND_SWAP, KIND_SUB, KIND_ADD: begin
               if (count_ff == '0) begin
                  req_err = ERR_EMPTY;
               end else if (count_ff == CNT_W'(1)) begin
                  req_err = ERR_ONE;
               end
            end
            default: begin
               req_err = ERR_OK;
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_err != ERR_OK) begin
                  state_in = ST_RESULT;
               end else begin
                  case (req_kind)
                     KIND_POP, KIND_STORE, KIND_PUT_NUM, KIND_PUT_CHAR,
                     KIND_DUP, KIND_SWAP, KIND_SUB, KIND_ADD: begin
                        state_in = ST_OPA;
                     end
                     KIND_REVERSE: begin
                        state_in = (count_ff >= CNT_W'(2)) ? ST_REV_A : ST_RESULT;
                     end
                     default: begin
                        state_in = ST_RESULT;
                     end
                  endcase
               end
            end
         end
         ST_OPA: begin
            case (kind_ff)
               KIND_SWAP, KIND_SUB, KIND_ADD: begin
                  state_in = ST_OPB;
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_OPB: begin
            state_in = (kind_ff == KIND_SWAP) ? ST_SWAP2 : ST_RESULT;
         end
         ST_SWAP2: begin
            state_in = ST_RESULT;
         end
         ST_REV_A: begin
            state_in = ST_REV_B;
         end
         ST_REV_B: begin
            state_in = ST_REV_C;
         end
         ST_REV_C: begin
            state_in = ST_REV_D;
         end
         ST_REV_D: begin
            state_in = rev_more ? ST_REV_B : ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and RAM control for each state.
   always_comb begin
      count_in      = count_ff;
      halted_in     = halted_ff;
      kind_in       = kind_ff;
      err_in        = err_ff;
      store_in      = store_ff;
      opa_in        = opa_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      emit_in       = emit_ff;
      emit_valid_in = emit_valid_ff;
      emit_char_in  = emit_char_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      mem_we    = 1'b0;
      mem_waddr = top_addr;
      mem_wdata = opa_ff;
      // In idle the top of stack is read so its data is ready in the next state.
      mem_raddr = top_addr;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               kind_in       = req_kind;
               err_in        = req_err;
               emit_in       = '0;
               emit_valid_in = 1'b0;
               emit_char_in  = 1'b0;
               if (req_err != ERR_OK) begin
                  halted_in = 1'b1;
               end else if (req_kind == KIND_PUSH) begin
                  mem_we    = 1'b1;
                  mem_waddr = next_addr;
                  mem_wdata = to_word(signed'(req_tdata));
                  count_in  = count_ff + CNT_W'(1);
               end else if (req_kind == KIND_REVERSE) begin
                  lo_in = '0;
                  hi_in = top_addr;
               end
            end
         end
         ST_OPA: begin
            // mem_rdata holds the top of stack.
            case (kind_ff)
               KIND_POP, KIND_STORE, KIND_PUT_NUM, KIND_PUT_CHAR: begin
                  count_in = count_ff - CNT_W'(1);
                  if (kind_ff == KIND_STORE) begin
                     store_in = mem_rdata;
                  end
                  if (kind_ff == KIND_PUT_NUM || kind_ff == KIND_PUT_CHAR) begin
                     emit_in       = to_out(mem_rdata);
                     emit_valid_in = 1'b1;
                     emit_char_in  = (kind_ff == KIND_PUT_CHAR);
                  end
               end
               KIND_DUP: begin
                  mem_we    = 1'b1;
                  mem_waddr = next_addr;
                  mem_wdata = mem_rdata;
                  count_in  = count_ff + CNT_W'(1);
               end
               KIND_SWAP, KIND_SUB, KIND_ADD: begin
                  opa_in    = mem_rdata;
                  mem_raddr = second_addr;
               end
               default: begin
                  opa_in = opa_ff;
               end
            endcase
         end
         ST_OPB: begin
            // opa_ff is the top, mem_rdata the item below it.
            case (kind_ff)
               KIND_SWAP: begin
                  mem_we    = 1'b1;
                  mem_waddr = top_addr;
                  mem_wdata = mem_rdata;
               end
               KIND_SUB: begin
                  mem_we    = 1'b1;
                  mem_waddr = second_addr;
                  mem_wdata = opa_ff - mem_rdata;
                  count_in  = count_ff - CNT_W'(1);
               end
               KIND_ADD: begin
                  mem_we    = 1'b1;
                  mem_waddr = second_addr;
                  mem_wdata = opa_ff + mem_rdata;
                  count_in  = count_ff - CNT_W'(1);
               end
               default: begin
                  mem_we = 1'b0;
               end
            endcase
         end
         ST_SWAP2: begin
            mem_we    = 1'b1;
            mem_waddr = second_addr;
            mem_wdata = opa_ff;
         end
         ST_REV_A: begin
            mem_raddr = lo_ff;
         end
         ST_REV_B: begin
            mem_raddr = hi_ff;
            opa_in    = mem_rdata;
         end
         ST_REV_C: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = mem_rdata;
         end
         ST_REV_D: begin
            // Write the saved low word high and start reading the next low word;
            // the two addresses never meet while the sweep continues.
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            mem_wdata = opa_ff;
            mem_raddr = lo_ff + ADDR_W'(1);
            lo_in     = lo_ff + ADDR_W'(1);
            hi_in     = hi_ff - ADDR_W'(1);
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = emit_char_ff;
               rsp_tdata_in  = {{RSP_PAD_W{1'b0}},
                                err_ff,
                                DEPTH_W'(count_ff),
                                to_out(store_ff),
                                emit_valid_ff,
                                emit_ff};
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         halted_ff     <= 1'b0;
         store_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         halted_ff     <= halted_in;
         store_ff      <= store_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      err_ff        <= err_in;
      opa_ff        <= opa_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      emit_ff       <= emit_in;
      emit_valid_ff <= emit_valid_in;
      emit_char_ff  <= emit_char_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[hdl/sme_ram.sv]
module sme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sme_checker.sv]
`include "stack_machine_execute_top_assert.svh"

module sme_checker
   import sme_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   // A stalled response beat keeps its contents.
   `SME_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // A character flag or a nonzero value only comes with an emitted value.
   `SME_ASSERT_NOW(a_emit_clean, rsp_tvalid && !rsp_tdata[OUT_VALID_BIT], !rsp_tuser && rsp_tdata[OUT_VALUE_LSB +: OUT_W] == '0, "stray output value")

   // A faulting or halted instruction never emits.
   `SME_ASSERT_NOW(a_err_no_emit, rsp_tvalid && rsp_tdata[ERR_LSB +: ERR_W] != ERR_OK, !rsp_tdata[OUT_VALID_BIT], "value emitted with an error")

   // The reported depth stays within the stack.
   `SME_ASSERT_NOW(a_depth_bound, rsp_tvalid, rsp_tdata[DEPTH_LSB +: DEPTH_W] <= DEPTH_W'(STACK_DEPTH), "stack depth out of range")

endmodule

bind stack_machine_execute_top sme_checker u_sme_checker (.*);

[dv/stack_machine_execute_top_tb.sv]
`timescale 1ns / 1ps

module stack_machine_execute_top_tb;
   import sme_pkg::*;

   // Kinds that the block treats as no-ops.
   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 4'd10;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 4'd15;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 680;
   // The random walk is sent toward the full stack starting at this item.
   localparam int DEEP_AT       = 60;
   localparam int MAX_GAP       = 13;
   // The long receiver hold-off starts at this response beat and lasts this
   // many cycles.
   localparam int HOLD_AT_BEAT  = 40;
   localparam int HOLD_CYCLES   = 200;
   // Cycles to watch for stray responses after the last expected one.
   localparam int DRAIN_CYCLES  = 40;

   // One response, in the order of the fields on rsp_tdata and rsp_tuser.
   typedef struct packed {
      logic [OUT_W-1:0]   out_value;
      logic               out_valid;
      logic               out_is_char;
      logic [OUT_W-1:0]   stored_value;
      logic [DEPTH_W-1:0] stack_depth;
      err_type            error_code;
   } sm_result_type;

   // One row of the directed table. When typed is set, known_res is the
   // response that is expected. Otherwise the predictor supplies it.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PUSH_W-1:0] value;
      logic              typed;
      sm_result_type     known_res;
   } stim_row_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PUSH_W-1:0]      req_tdata  = '0;   // [31:0] push_value
   logic [KIND_W-1:0]      req_tuser  = '0;   // [3:0] kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [31:0] out_value, [32] out_valid,
                                              // [64:33] stored_value,
                                              // [73:65] stack_depth,
                                              // [76:74] error_code, [79:77] zero
   logic                   rsp_tuser;         // [0] out_is_char

   // Predictor state: the stack, its depth, the store register and the halt
   // flag.
   word_type   stack_words [STACK_DEPTH];
   int         depth_count    = 0;
   word_type   store_word     = '0;
   bit         machine_halted = 1'b0;

   sm_result_type pending_results [$];
   int            fail_count = 0;
   int            rsp_count  = 0;

   // Directed table. It walks from an empty stack through every operation but pop.
   // It also checks that the add and sub results wrap at the word extremes.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{KIND_REVERSE,      32'h0000_0000, 1'b1, '{'0, 1'b0, 1'b0, '0, 9'd0, ERR_OK}},
      '{KIND_UNUSED_LAST,  32'hFFFF_FFFF, 1'b1, '{'0, 1'b0, 1'b0, '0, 9'd0, ERR_OK}},
      '{KIND_PUSH,         32'h7FFF_FFFF, 1'b1, '{'0, 1'b0, 1'b0, '0, 9'd1, ERR_OK}},
      '{KIND_REVERSE,      32'h0000_0000, 1'b1, '{'0, 1'b0, 1'b0, '0, 9'd1, ERR_OK}},
      '{KIND_PUSH,         32'h8000_0000, 1'b1, '{'0, 1'b0, 1'b0, '0, 9'd2, ERR_OK}},
      '{KIND_ADD,          32'h0000_0000, 1'b0, '0},
      '{KIND_PUT_NUM,      32'h0000_0000, 1'b0, '0},
      '{KIND_PUSH,         32'h0000_0041, 1'b1, '{'0, 1'b0, 1'b0, '0, 9'd1, ERR_OK}},
      '{KIND_DUP,          32'h0000_0000, 1'b0, '0},
      '{KIND_PUT_CHAR,     32'h0000_0000, 1'b0, '0},
      '{KIND_STORE,        32'h0000_0000, 1'b0, '0},
      '{KIND_PUSH,         32'hFFFF_FFFF, 1'b1,
        '{'0, 1'b0, 1'b0, 32'h0000_0041, 9'd1, ERR_OK}},
      '{KIND_PUSH,         32'h0000_0001, 1'b0, '0},
      '{KIND_SUB,          32'h0000_0000, 1'b0, '0},
      '{KIND_PUSH,         32'h8000_0000, 1'b0, '0},
      '{KIND_SWAP,         32'h0000_0000, 1'b0, '0},
      '{KIND_SUB,          32'h0000_0000, 1'b0, '0},
      '{KIND_PUSH,         32'h7FFF_FFFF, 1'b0, '0},
      '{KIND_ADD,          32'h0000_0000, 1'b0, '0},
      '{KIND_PUSH,         32'h5555_5555, 1'b0, '0},
      '{KIND_PUSH,         32'hAAAA_AAAA, 1'b0, '0},
      '{KIND_REVERSE,      32'h0000_0000, 1'b0, '0},
      '{KIND_UNUSED_FIRST, 32'h1234_5678, 1'b0, '0},
      '{KIND_STORE,        32'h0000_0000, 1'b0, '0},
      '{KIND_PUT_NUM,      32'h0000_0000, 1'b0, '0}
   };

   stack_machine_execute_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one instruction to the predicted machine and returns the
   // response that the block must give for it.
   function automatic sm_result_type execute_instr(input logic [KIND_W-1:0] kind,
                                                   input logic signed [PUSH_W-1:0] value);
      sm_result_type res;
      word_type      top;
      word_type      second;
      word_type      held;
      int            lo;
      int            hi;
      res = '0;
      res.error_code = ERR_OK;
      if (machine_halted) begin
         res.error_code = ERR_HALTED;
      end else begin
         case (kind)
            KIND_PUSH: begin
               if (depth_count >= STACK_DEPTH) begin
                  res.error_code = ERR_FULL;
               end else begin
                  stack_words[depth_count] = word_type'(value);
                  depth_count++;
               end
            end
            KIND_POP, KIND_STORE, KIND_PUT_NUM, KIND_PUT_CHAR: begin
               if (depth_count == 0) begin
                  res.error_code = ERR_EMPTY;
               end else begin
                  depth_count--;
                  top = stack_words[depth_count];
                  if (kind == KIND_STORE) begin
                     store_word = top;
                  end else if (kind != KIND_POP) begin
                     res.out_value   = OUT_W'(signed'(top));
                     res.out_valid   = 1'b1;
                     res.out_is_char = (kind == KIND_PUT_CHAR);
                  end
               end
            end
            KIND_REVERSE: begin
               lo = 0;
               hi = depth_count - 1;
               while (lo < hi) begin
                  held            = stack_words[lo];
                  stack_words[lo] = stack_words[hi];
                  stack_words[hi] = held;
                  lo++;
                  hi--;
               end
            end
            KIND_DUP: begin
               if (depth_count == 0) begin
                  res.error_code = ERR_EMPTY;
               end else if (depth_count >= STACK_DEPTH) begin
                  res.error_code = ERR_FULL;
               end else begin
                  stack_words[depth_count] = stack_words[depth_count-1];
                  depth_count++;
               end
            end
            KIND_SWAP, KIND_SUB, KIND_ADD: begin
               if (depth_count == 0) begin
                  res.error_code = ERR_EMPTY;
               end else if (depth_count == 1) begin
                  res.error_code = ERR_ONE;
               end else begin
                  top    = stack_words[depth_count-1];
                  second = stack_words[depth_count-2];
                  if (kind == KIND_SWAP) begin
                     stack_words[depth_count-1] = second;
                     stack_words[depth_count-2] = top;
                  end else begin
                     stack_words[depth_count-2] =
                        (kind == KIND_SUB) ? top - second : top + second;
                     depth_count--;
                  end
               end
            end
            default: begin
            end
         endcase
         if (res.error_code != ERR_OK) machine_halted = 1'b1;
      end
      res.stored_value = OUT_W'(signed'(store_word));
      res.stack_depth  = DEPTH_W'(depth_count);
      return res;
   endfunction

   // True when the kind cannot fault at the given depth.
   function automatic bit kind_is_safe(input logic [KIND_W-1:0] kind, input int depth);
      case (kind)
         KIND_PUSH:                                       return depth < STACK_DEPTH;
         KIND_POP, KIND_STORE, KIND_PUT_NUM, KIND_PUT_CHAR: return depth >= 1;
         KIND_DUP:           return depth >= 1 && depth < STACK_DEPTH;
         KIND_SWAP, KIND_SUB, KIND_ADD:                   return depth >= 2;
         default:                                         return 1'b1;
      endcase
   endfunction

   // Picks a kind that cannot fault. While the walk grows the stack, push and
   // dup dominate. While it drains, the shrinking kinds dominate. A small
   // share goes to reverse and to the unused kinds.
   function automatic logic [KIND_W-1:0] pick_safe_kind(input bit growing);
      logic [KIND_W-1:0] shrinkers [7];
      logic [KIND_W-1:0] kind;
      int                roll;
      shrinkers = '{KIND_POP, KIND_STORE, KIND_PUT_NUM, KIND_PUT_CHAR,
                    KIND_SWAP, KIND_SUB, KIND_ADD};
      do begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
         end else if (roll < 7) begin
            kind = KIND_REVERSE;
         end else if ((roll < 95) == growing) begin
            kind = ($urandom_range(0, 3) == 0) ? KIND_DUP : KIND_PUSH;
         end else begin
            kind = shrinkers[$urandom_range(0, 6)];
         end
      end while (!kind_is_safe(kind, depth_count));
      return kind;
   endfunction

   // Random word. One time in eight it is one of the extremes.
   function automatic logic [PUSH_W-1:0] rand_word();
      logic [PUSH_W-1:0] corners [4];
      corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   // Idle cycles before the next beat. Each side switches at random between
   // stretches of back-to-back beats and stretches with random gaps.
   function automatic int draw_gap(inout int left, inout bit fast);
      if (left == 0) begin
         fast = ($urandom_range(0, 3) == 0);
         left = $urandom_range(5, 40);
      end
      left--;
      return fast ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic compare_field(input string field_name, input logic [OUT_W-1:0] want,
                                input logic [OUT_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
      end
   endtask

   // Sender. It offers one instruction, holds it until the block takes it, and
   // then queues the expected response. tvalid is lowered only when a gap
   // follows, so a back-to-back beat never sees two assignments in one step.
   int send_left = 0;
   bit send_fast = 1'b0;

   task automatic issue_instr(input logic [KIND_W-1:0] kind, input logic [PUSH_W-1:0] value,
                              input bit typed, input sm_result_type known_res);
      int            gap;
      sm_result_type predicted;
      gap = draw_gap(send_left, send_fast);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = execute_instr(kind, value);
      pending_results.push_back(typed ? known_res : predicted);
   endtask

   // The sender pauses here until every expected response has come back.
   task automatic wait_for_drain();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int      target;
      bit      growing;
      err_type fault;
      logic [KIND_W-1:0] empty_faulters [8];
      logic [KIND_W-1:0] pair_ops [3];
      empty_faulters = '{KIND_POP, KIND_STORE, KIND_PUT_NUM, KIND_PUT_CHAR,
                         KIND_DUP, KIND_SWAP, KIND_SUB, KIND_ADD};
      pair_ops       = '{KIND_SWAP, KIND_SUB, KIND_ADD};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         issue_instr(directed_rows[i].kind, directed_rows[i].value,
                     directed_rows[i].typed, directed_rows[i].known_res);
      end
      req_tvalid <= 1'b0;
      wait_for_drain();

      // Random walk with no faults. The depth target moves between small
      // values. Once it is the full stack, so the walk climbs to the top and
      // drains back again.
      target  = $urandom_range(0, 24);
      growing = target > depth_count;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == DEEP_AT) begin
            target  = STACK_DEPTH;
            growing = 1'b1;
         end else if (growing ? depth_count >= target : depth_count <= target) begin
            target  = $urandom_range(0, 24);
            growing = target > depth_count;
         end
         issue_instr(pick_safe_kind(growing), rand_word(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      wait_for_drain();

      // Set up one fault and trigger it. After the fault, every beat must get
      // the halted answer.
      fault = err_type'($urandom_range(ERR_EMPTY, ERR_FULL));
      case (fault)
         ERR_EMPTY: begin
            while (depth_count > 0) issue_instr(KIND_POP, rand_word(), 1'b0, '0);
            issue_instr(empty_faulters[$urandom_range(0, 7)], rand_word(), 1'b0, '0);
         end
         ERR_ONE: begin
            while (depth_count > 1) issue_instr(KIND_POP, rand_word(), 1'b0, '0);
            if (depth_count == 0) issue_instr(KIND_PUSH, rand_word(), 1'b0, '0);
            issue_instr(pair_ops[$urandom_range(0, 2)], rand_word(), 1'b0, '0);
         end
         default: begin
            while (depth_count < STACK_DEPTH) issue_instr(KIND_PUSH, rand_word(), 1'b0, '0);
            issue_instr(($urandom_range(0, 1) == 0) ? KIND_PUSH : KIND_DUP,
                        rand_word(), 1'b0, '0);
         end
      endcase
      repeat (8) issue_instr(KIND_W'($urandom_range(0, 15)), rand_word(), 1'b0, '0);
      req_tvalid <= 1'b0;

      // Wait for the last response, then watch a while longer for stray beats.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver. It takes response beats with random gaps, and holds off once
   // for a long stretch so that the block fills and stalls req_tready.
   initial begin : response_check
      int            gap;
      int            rcv_left;
      bit            rcv_fast;
      sm_result_type want;
      sm_result_type got;
      rcv_left = 0;
      rcv_fast = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = (rsp_count == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_gap(rcv_left, rcv_fast);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rsp_count++;
         got.out_value    = rsp_tdata[OUT_VALUE_LSB +: OUT_W];
         got.out_valid    = rsp_tdata[OUT_VALID_BIT];
         got.out_is_char  = rsp_tuser;
         got.stored_value = rsp_tdata[STORED_LSB +: OUT_W];
         got.stack_depth  = rsp_tdata[DEPTH_LSB +: DEPTH_W];
         got.error_code   = err_type'(rsp_tdata[ERR_LSB +: ERR_W]);
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: response beat with nothing expected, expected none, actual %h",
                     $time, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            compare_field("out_value",    want.out_value,    got.out_value);
            compare_field("out_valid",    OUT_W'(want.out_valid),   OUT_W'(got.out_valid));
            compare_field("out_is_char",  OUT_W'(want.out_is_char), OUT_W'(got.out_is_char));
            compare_field("stored_value", want.stored_value, got.stored_value);
            compare_field("stack_depth",  OUT_W'(want.stack_depth), OUT_W'(got.stack_depth));
            compare_field("error_code",   OUT_W'(want.error_code),  OUT_W'(got.error_code));
            compare_field("tdata padding", '0, OUT_W'(rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W]));
         end
      end
   end

   // Timeout, far beyond the slowest correct run.
   initial begin : watchdog
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
